[rtl/core/stb_pkg.sv]
package stb_pkg;

   localparam int unsigned DOMAIN_W = 3;
   localparam int unsigned SLOT_W = 4;
   localparam int unsigned CNT_W = 5;
   localparam logic [CNT_W-1:0] MAX_FIRES = 5'd16;

   typedef enum logic [2:0] {
      OP_ARM        = 3'd0,
      OP_DISARM     = 3'd1,
      OP_TICK       = 3'd2,
      OP_ANY_QUERY  = 3'd3,
      OP_SLOT_QUERY = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_ARMED = 2'd1,
      STAT_ZERO  = 2'd2
   } stat_type;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [3:0]  slot;
      logic [2:0]  domain;
      logic [15:0] event_id;
      logic [7:0]  owner_tag;
      logic        has_owner;
      logic [15:0] start_ticks;
      logic [15:0] reload_ticks;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [1:0]  status;
      logic        flag;
      logic [3:0]  fired_slot;
      logic [15:0] fired_event_id;
      logic [7:0]  fired_owner;
      logic        publish;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic                armed;
      logic [DOMAIN_W-1:0] domain;
      logic [15:0]         remaining;
      logic [15:0]         interval;
      logic [15:0]         event_id;
      logic [7:0]          owner;
      logic                publish;
   } slot_type;

   typedef struct packed {
      logic shift;
      logic load;
      logic clear;
   } cell_ctl_type;

   typedef struct packed {
      logic fire;
      logic busy;
   } scan_info_type;

   function automatic rsp_type make_status(input stat_type st, input logic flag);
      rsp_type r;
      r = '0;
      r.status = st;
      r.flag = flag;
      r.last = 1'b1;
      return r;
   endfunction

endpackage

[rtl/core/stb_if.sv]
interface stb_req_if import stb_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface stb_rsp_if import stb_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

[rtl/core/stb_cell.sv]
module stb_cell import stb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  slot_type     src_rec,
   input  slot_type     load_rec,
   output slot_type     rec
);

   slot_type rec_ff;
   slot_type rec_in;

   always_comb begin
      rec_in = rec_ff;
      if (ctl.shift) begin
         rec_in = src_rec;
      end else if (ctl.load) begin
         rec_in = load_rec;
      end else if (ctl.clear) begin
         rec_in.armed = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.armed <= 1'b0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign rec = rec_ff;

endmodule

[rtl/core/stb_tick_unit.sv]
module stb_tick_unit import stb_pkg::*; (
   input  slot_type            rec,
   input  logic                tick,
   input  logic [DOMAIN_W-1:0] domain,
   input  logic                all,
   input  logic                room,
   output slot_type            next_rec,
   output scan_info_type       info
);

   logic        match;
   logic [15:0] dec;

   assign match = rec.armed && (all || rec.domain == domain);
   assign dec = rec.remaining - 16'd1;

   always_comb begin
      next_rec = rec;
      info.fire = 1'b0;
      info.busy = !tick && match;
      if (tick && match && room) begin
         if (dec == 16'd0) begin
            info.fire = 1'b1;
            if (rec.interval != 16'd0) begin
               next_rec.remaining = rec.interval;
            end else begin
               next_rec.armed = 1'b0;
            end
         end else begin
            next_rec.remaining = dec;
         end
      end
   end

endmodule

[rtl/core/software_timer_bank.sv]
// Timer bank with TIMERS slots spread over DOMAINS tick domains.
// req_chan carries one operation word: arm, disarm, tick of a domain,
// any-armed query of a domain (or of all domains) and slot-armed query.
// rsp_chan returns result words; the final word of an operation has last set.
// Arm, disarm, slot query and rejected operations answer in one word that
// is visible the cycle after acceptance.
// A tick or a domain query rotates the slot ring once through the update
// unit at the ring head, one slot per cycle unless a fire word must wait,
// and then passes through a flush state. A tick emits one fire word per
// expiring slot in slot order, or one empty status word if nothing expires.
// One new operation is taken only once the previous one has finished and
// the output register is free or being drained.
// When rsp_chan stalls, the ring holds whenever a new fire word cannot be
// parked, and every word waits in the output register; none is lost.
// Reset disarms every slot and empties the output; the bank is ready in the
// first cycle after reset is released.
module software_timer_bank import stb_pkg::*; #(
   parameter int unsigned TIMERS = 16,
   parameter int unsigned DOMAINS = 4
) (
   input  logic         clock,
   input  logic         reset,
   stb_req_if.sink      req_chan,
   stb_rsp_if.source    rsp_chan
);

   localparam int unsigned IDX_W = (TIMERS > 1) ? $clog2(TIMERS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMERS - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FLUSH
   } state_type;

   state_type           state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                pend_valid_ff, pend_valid_in;
   rsp_type             pend_ff, pend_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                tick_ff, tick_in;
   logic                all_ff, all_in;
   logic [DOMAIN_W-1:0] dom_ff, dom_in;

   slot_type            cell_rec [TIMERS];
   slot_type            head_next;
   slot_type            arm_rec;
   scan_info_type       info;
   logic [TIMERS-1:0]   armed_vec;
   logic [IDX_W-1:0]    req_idx;
   logic                ok_slot;
   logic                dom_ok;
   logic                dom_all;
   logic                slot_armed;
   logic                out_free;
   logic                req_ready;
   logic                accept;
   logic                advance;
   logic                arm_load;
   logic                disarm_clear;
   req_type             req;

   assign req = req_chan.data;
   assign req_idx = IDX_W'(req.slot);
   assign ok_slot = 32'(req.slot) < TIMERS;
   assign dom_ok = 32'(req.domain) < DOMAINS;
   assign dom_all = 32'(req.domain) == DOMAINS;
   assign slot_armed = ok_slot && armed_vec[req_idx];

   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_ready = (state_ff == S_IDLE) && out_free;
   assign accept = req_chan.valid && req_ready;
   assign advance = (state_ff == S_SCAN) && !(info.fire && pend_valid_ff && !out_free);

   always_comb begin
      arm_rec.armed = 1'b1;
      arm_rec.domain = req.domain;
      arm_rec.remaining = req.start_ticks;
      arm_rec.interval = req.reload_ticks;
      arm_rec.event_id = req.event_id;
      arm_rec.owner = req.has_owner ? req.owner_tag : 8'd0;
      arm_rec.publish = !req.has_owner;
   end

   stb_tick_unit u_tick (
      .rec      (cell_rec[0]),
      .tick     (tick_ff),
      .domain   (dom_ff),
      .all      (all_ff),
      .room     (cnt_ff != MAX_FIRES),
      .next_rec (head_next),
      .info     (info)
   );

   for (genvar i = 0; i < TIMERS; i++) begin : g_cell
      cell_ctl_type ctl;
      slot_type     src;

      assign ctl.shift = advance;
      assign ctl.load = arm_load && (req_idx == IDX_W'(i));
      assign ctl.clear = disarm_clear && (req_idx == IDX_W'(i));
      assign src = (i == TIMERS - 1) ? head_next : cell_rec[(i + 1) % TIMERS];
      assign armed_vec[i] = cell_rec[i].armed;

      stb_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .src_rec  (src),
         .load_rec (arm_rec),
         .rec      (cell_rec[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_in = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in = pend_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      tick_in = tick_ff;
      all_in = all_ff;
      dom_in = dom_ff;
      arm_load = 1'b0;
      disarm_clear = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_in = make_status(STAT_OK, 1'b0);
               idx_in = '0;
               cnt_in = '0;
               busy_in = 1'b0;
               pend_valid_in = 1'b0;
               dom_in = req.domain;
               case (req.opcode)
                  OP_ARM: begin
                     if (slot_armed) begin
                        rsp_in = make_status(STAT_ARMED, 1'b0);
                     end else if (req.start_ticks == 16'd0) begin
                        rsp_in = make_status(STAT_ZERO, 1'b0);
                     end else if (ok_slot && dom_ok) begin
                        rsp_in = make_status(STAT_OK, 1'b1);
                        arm_load = 1'b1;
                     end
                  end
                  OP_DISARM: begin
                     rsp_in = make_status(STAT_OK, slot_armed);
                     disarm_clear = ok_slot;
                  end
                  OP_TICK: begin
                     if (dom_ok) begin
                        rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                        rsp_in = rsp_ff;
                        tick_in = 1'b1;
                        all_in = 1'b0;
                        state_in = S_SCAN;
                     end
                  end
                  OP_ANY_QUERY: begin
                     if (dom_ok || dom_all) begin
                        rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
                        rsp_in = rsp_ff;
                        tick_in = 1'b0;
                        all_in = dom_all;
                        state_in = S_SCAN;
                     end
                  end
                  OP_SLOT_QUERY: begin
                     rsp_in = make_status(STAT_OK, slot_armed);
                  end
                  default: begin
                     rsp_in = make_status(STAT_OK, 1'b0);
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (advance) begin
               idx_in = idx_ff + 1'b1;
               busy_in = busy_ff || info.busy;
               if (info.fire) begin
                  cnt_in = cnt_ff + 1'b1;
                  pend_valid_in = 1'b1;
                  pend_in = '0;
                  pend_in.kind = 1'b1;
                  pend_in.fired_slot = SLOT_W'(idx_ff);
                  pend_in.fired_event_id = cell_rec[0].event_id;
                  pend_in.fired_owner = cell_rec[0].publish ? 8'd0 : cell_rec[0].owner;
                  pend_in.publish = cell_rec[0].publish;
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in = pend_ff;
                  end
               end
               if (idx_ff == LAST_IDX) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (!tick_ff) begin
                  rsp_in = make_status(STAT_OK, busy_ff);
               end else if (pend_valid_ff) begin
                  rsp_in = pend_ff;
                  rsp_in.last = 1'b1;
               end else begin
                  rsp_in = make_status(STAT_OK, 1'b0);
               end
               pend_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      pend_ff <= pend_in;
      dom_ff <= dom_in;
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
         idx_ff <= '0;
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         tick_ff <= 1'b0;
         all_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         tick_ff <= tick_in;
         all_ff <= all_in;
      end
   end

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data = rsp_ff;

endmodule

[dv/tb_top.sv]
module tb_top;
   import stb_pkg::*;

   localparam int unsigned TIMERS = 16;
   localparam int unsigned DOMAINS = 4;
   localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
   localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;
   localparam logic KIND_FIRE = 1'b1;
   localparam int unsigned DOMAIN_CODES = 1 << DOMAIN_W;
   localparam int unsigned RSP_HOLD_CYCLES = 400;
   localparam int unsigned SETTLE_CYCLES = 40;

   typedef struct {
      req_type word;
      bit      drain;
   } op_entry_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   stb_req_if req_if ();
   stb_rsp_if rsp_if ();

   software_timer_bank #(
      .TIMERS (TIMERS),
      .DOMAINS(DOMAINS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_if),
      .rsp_chan(rsp_if)
   );

   // bank state as seen by the predictor
   logic        timer_armed   [TIMERS];
   logic [2:0]  timer_domain  [TIMERS];
   logic [15:0] timer_left    [TIMERS];
   logic [15:0] timer_reload  [TIMERS];
   logic [15:0] timer_event   [TIMERS];
   logic [7:0]  timer_owner   [TIMERS];
   logic        timer_publish [TIMERS];

   op_entry_type op_backlog[$];
   rsp_type due_words[$];
   rsp_type want_word;
   bit      req_took = 1'b0;
   bit      calm = 1'b0;
   bit      rsp_hold_req = 1'b0;
   int      hold_left = 0;
   int      mismatches = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type answer(input stat_type st, input logic flag);
      rsp_type r;
      r = '0;
      r.status = st;
      r.flag = flag;
      r.last = 1'b1;
      return r;
   endfunction

   function automatic string word_text(input rsp_type x);
      return $sformatf(
         "kind=%0d status=%0d flag=%0d slot=%0d event=%h owner=%h publish=%0d last=%0d",
         x.kind, x.status, x.flag, x.fired_slot, x.fired_event_id,
         x.fired_owner, x.publish, x.last);
   endfunction

   task automatic advance_bank(input req_type w);
      rsp_type fire;
      rsp_type prev;
      logic    have_prev;
      logic    any;
      int      i;
      case (w.opcode)
         OP_ARM: begin
            if (timer_armed[w.slot]) begin
               due_words.push_back(answer(STAT_ARMED, 1'b0));
            end else if (w.start_ticks == 0) begin
               due_words.push_back(answer(STAT_ZERO, 1'b0));
            end else if (w.domain >= DOMAINS) begin
               due_words.push_back(answer(STAT_OK, 1'b0));
            end else begin
               timer_armed[w.slot] = 1'b1;
               timer_domain[w.slot] = w.domain;
               timer_left[w.slot] = w.start_ticks;
               timer_reload[w.slot] = w.reload_ticks;
               timer_event[w.slot] = w.event_id;
               timer_owner[w.slot] = w.has_owner ? w.owner_tag : 8'h00;
               timer_publish[w.slot] = !w.has_owner;
               due_words.push_back(answer(STAT_OK, 1'b1));
            end
         end
         OP_DISARM: begin
            due_words.push_back(answer(STAT_OK, timer_armed[w.slot]));
            timer_armed[w.slot] = 1'b0;
            timer_left[w.slot] = '0;
            timer_reload[w.slot] = '0;
         end
         OP_TICK: begin
            have_prev = 1'b0;
            prev = '0;
            if (w.domain < DOMAINS) begin
               for (i = 0; i < TIMERS; i++) begin
                  if (timer_armed[i] && timer_domain[i] == w.domain) begin
                     timer_left[i] = timer_left[i] - 16'd1;
                     if (timer_left[i] == 0) begin
                        if (timer_reload[i] != 0) timer_left[i] = timer_reload[i];
                        else timer_armed[i] = 1'b0;
                        fire = '0;
                        fire.kind = KIND_FIRE;
                        fire.fired_slot = 4'(i);
                        fire.fired_event_id = timer_event[i];
                        fire.fired_owner = timer_publish[i] ? 8'h00 : timer_owner[i];
                        fire.publish = timer_publish[i];
                        if (have_prev) due_words.push_back(prev);
                        prev = fire;
                        have_prev = 1'b1;
                     end
                  end
               end
            end
            if (have_prev) begin
               prev.last = 1'b1;
               due_words.push_back(prev);
            end else begin
               due_words.push_back(answer(STAT_OK, 1'b0));
            end
         end
         OP_ANY_QUERY: begin
            any = 1'b0;
            for (i = 0; i < TIMERS; i++) begin
               if (timer_armed[i] && (w.domain == DOMAINS || timer_domain[i] == w.domain))
                  any = 1'b1;
            end
            due_words.push_back(answer(STAT_OK, (w.domain <= DOMAINS) ? any : 1'b0));
         end
         OP_SLOT_QUERY: begin
            due_words.push_back(answer(STAT_OK, timer_armed[w.slot]));
         end
         default: begin
            due_words.push_back(answer(STAT_OK, 1'b0));
         end
      endcase
   endtask

   function automatic logic [2:0] pick_domain();
      if ($urandom_range(99) < 88) return 3'($urandom_range(DOMAINS - 1));
      return 3'($urandom_range(DOMAIN_CODES - 1, DOMAINS));
   endfunction

   function automatic req_type random_item();
      req_type w;
      int      pick;
      w.opcode = OP_ARM;
      w.slot = 4'($urandom);
      w.domain = pick_domain();
      w.event_id = 16'($urandom);
      w.owner_tag = 8'($urandom);
      w.has_owner = 1'($urandom);
      w.start_ticks = 16'($urandom);
      w.reload_ticks = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 33) begin
         pick = $urandom_range(99);
         if (pick < 5) w.start_ticks = '0;
         else if (pick < 70) w.start_ticks = 16'($urandom_range(3, 1));
         else if (pick < 88) w.start_ticks = 16'($urandom_range(24, 4));
         else if (pick < 92) w.start_ticks = 16'hFFFF;
         pick = $urandom_range(99);
         if (pick < 45) w.reload_ticks = '0;
         else if (pick < 80) w.reload_ticks = 16'($urandom_range(4, 1));
         else if (pick < 95) w.reload_ticks = 16'($urandom_range(30, 5));
      end else if (pick < 45) begin
         w.opcode = OP_DISARM;
      end else if (pick < 80) begin
         w.opcode = OP_TICK;
      end else if (pick < 88) begin
         w.opcode = OP_ANY_QUERY;
         w.domain = 3'($urandom_range(DOMAIN_CODES - 1));
      end else if (pick < 96) begin
         w.opcode = OP_SLOT_QUERY;
      end else begin
         w.opcode = 3'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
      end
      return w;
   endfunction

   function automatic req_type op_item(input logic [2:0] op, input logic [3:0] slot,
                                       input logic [2:0] domain);
      req_type w;
      w = random_item();
      w.opcode = op;
      w.slot = slot;
      w.domain = domain;
      return w;
   endfunction

   function automatic req_type arm_item(input logic [3:0] slot, input logic [2:0] domain,
                                        input logic [15:0] event_id, input logic [7:0] owner,
                                        input logic has_owner, input logic [15:0] start,
                                        input logic [15:0] reload);
      req_type w;
      w.opcode = OP_ARM;
      w.slot = slot;
      w.domain = domain;
      w.event_id = event_id;
      w.owner_tag = owner;
      w.has_owner = has_owner;
      w.start_ticks = start;
      w.reload_ticks = reload;
      return w;
   endfunction

   task automatic queue_op(input req_type w, input bit drain = 1'b0);
      op_entry_type e;
      e.word = w;
      e.drain = drain;
      op_backlog.push_back(e);
   endtask

   task automatic wait_backlog();
      while (op_backlog.size() != 0) @(posedge clock);
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data <= '0;
      end else begin
         if (req_took) void'(op_backlog.pop_front());
         if (req_if.valid && !req_took) begin
            // hold the offered word until taken
         end else if (op_backlog.size() == 0 ||
                      (op_backlog[0].drain && due_words.size() != 0) ||
                      (!calm && $urandom_range(99) < 23)) begin
            req_if.valid <= 1'b0;
         end else begin
            req_if.valid <= 1'b1;
            req_if.data <= op_backlog[0].word;
         end
      end
   end

   // receiver
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold_req) begin
         rsp_hold_req = 1'b0;
         hold_left = RSP_HOLD_CYCLES;
         rsp_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm || $urandom_range(99) >= 23;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         req_took = 1'b0;
         for (int i = 0; i < TIMERS; i++) begin
            timer_armed[i] = 1'b0;
            timer_domain[i] = '0;
            timer_left[i] = '0;
            timer_reload[i] = '0;
            timer_event[i] = '0;
            timer_owner[i] = '0;
            timer_publish[i] = 1'b0;
         end
      end else begin
         req_took = req_if.valid && req_if.ready;
         if (req_took) advance_bank(req_if.data);
         if (rsp_if.valid && rsp_if.ready) begin
            if (due_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected word: %s", word_text(rsp_if.data));
            end else begin
               want_word = due_words.pop_front();
               if (rsp_if.data.kind !== want_word.kind ||
                   rsp_if.data.status !== want_word.status ||
                   rsp_if.data.flag !== want_word.flag ||
                   rsp_if.data.fired_slot !== want_word.fired_slot ||
                   rsp_if.data.fired_event_id !== want_word.fired_event_id ||
                   rsp_if.data.fired_owner !== want_word.fired_owner ||
                   rsp_if.data.publish !== want_word.publish ||
                   rsp_if.data.last !== want_word.last) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("word mismatch at %0t", $realtime);
                     $display("  expected %s", word_text(want_word));
                     $display("  actual   %s", word_text(rsp_if.data));
                  end
               end
            end
         end
      end
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_op(arm_item(4'd0, 3'd0, 16'h1234, 8'h00, 1'b1, 16'h0000, 16'h0000));
      for (int s = 0; s < TIMERS; s++) begin
         queue_op(arm_item(4'(s), 3'd0,
                           (s == 0) ? 16'h0000 : (s == TIMERS - 1) ? 16'hFFFF : 16'($urandom),
                           (s % 2 == 0) ? 8'hFF : 8'h00, 1'(s % 2), 16'd1,
                           (s == 0) ? 16'hFFFF : (s % 3 == 0) ? 16'd1 : 16'd0));
      end
      queue_op(arm_item(4'd3, 3'd1, 16'hABCD, 8'h55, 1'b1, 16'h0000, 16'd2));
      queue_op(op_item(OP_ANY_QUERY, 4'd0, 3'(DOMAINS)));
      queue_op(op_item(OP_ANY_QUERY, 4'd0, 3'(DOMAIN_CODES - 1)));
      queue_op(op_item(OP_SLOT_QUERY, 4'd5, 3'd0));
      queue_op(op_item(OP_TICK, 4'd0, 3'd0));
      queue_op(op_item(OP_TICK, 4'd0, 3'd5));
      queue_op(op_item(OP_DISARM, 4'd0, 3'd0));
      queue_op(arm_item(4'd1, 3'(DOMAINS), 16'h0F0F, 8'hA5, 1'b1, 16'd5, 16'd0));
      queue_op(op_item(OP_UNKNOWN_HI - 3'd1, 4'd2, 3'd2));
      queue_op(op_item(OP_ANY_QUERY, 4'd0, 3'd2));
      wait_backlog();

      // stall the result side while the bank keeps getting work
      rsp_hold_req = 1'b1;
      for (int n = 0; n < 30; n++) queue_op(random_item());
      wait_backlog();
      queue_op(random_item(), 1'b1);

      for (int n = 0; n < 40; n++) queue_op(random_item());
      wait_backlog();
      calm = 1'b1;
      for (int n = 0; n < 50; n++) queue_op(random_item());
      wait_backlog();
      calm = 1'b0;
      for (int n = 0; n < 30; n++) queue_op(random_item());
      wait_backlog();

      while (due_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
